>>> sv/itf_pkg.sv
// Shared constants, state type and character helpers for the integer-to-text formatter.
`timescale 1ns / 1ps
`default_nettype none
package itf_pkg;

  // Text and digit store limits
  localparam logic [7:0] MAX_CHARS   = 8'd64;
  localparam int         DIGIT_DEPTH = 64;
  localparam int         DIGIT_AW    = $clog2(DIGIT_DEPTH);

  // Format flag bit positions
  localparam int FL_ZEROPAD = 0;
  localparam int FL_SIGNED  = 1;
  localparam int FL_PLUS    = 2;
  localparam int FL_SPACE   = 3;
  localparam int FL_LEFT    = 4;
  localparam int FL_PREFIX  = 5;
  localparam int FL_UPPER   = 6;

  // Radix limits and prefix radices
  localparam logic [5:0] RADIX_MIN = 6'd2;
  localparam logic [5:0] RADIX_MAX = 6'd36;
  localparam logic [5:0] RADIX_OCT = 6'd8;
  localparam logic [5:0] RADIX_HEX = 6'd16;

  // ASCII codes
  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_PLUS  = 8'h2b;
  localparam logic [7:0] CH_MINUS = 8'h2d;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_UA    = 8'h41;
  localparam logic [7:0] CH_LA    = 8'h61;
  localparam logic [7:0] CH_UX    = 8'h58;
  localparam logic [7:0] CH_LX    = 8'h78;

  // Sequencer states
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DIV,
    ST_SETUP,
    ST_LSP,
    ST_SIGN,
    ST_PRE0,
    ST_PREX,
    ST_ZPAD,
    ST_PZERO,
    ST_DFETCH,
    ST_DEMIT,
    ST_TSP,
    ST_ERR
  } itf_state_t;

  // Map a digit value to its ASCII character
  function automatic logic [7:0] digit_char(input logic [5:0] d, input logic upper);
    logic [7:0] d8;
    d8 = {2'b00, d};
    if (d < 6'd10) begin
      digit_char = CH_ZERO + d8;
    end else if (upper) begin
      digit_char = CH_UA + d8 - 8'd10;
    end else begin
      digit_char = CH_LA + d8 - 8'd10;
    end
  endfunction

endpackage
`default_nettype wire

>>> sv/integer_to_text_formatter_top.sv
// Top level of the integer-to-text formatter: bit-serial radix divider, digit store, text sequencer.
`timescale 1ns / 1ps
`default_nettype none
// Formats one 64-bit value as printf-style text, one character per output word. One value
// is in flight at a time; in_ready is high only while the block is idle. Digits come from a
// restoring divider that retires one quotient bit per cycle, taking one digit from each
// pass over the 64-bit word until the quotient is zero (a value has 1..64 digits, e.g. 20
// for a large decimal value, 64 for a full binary value). A setup state follows; padding,
// sign and prefix characters then go out at one word per cycle while the output is not
// stalled, and each digit as a fetch from the registered digit store, then the word. Each
// segment, empty or not, that comes before the segment holding the last word also takes
// a closing step. A radix outside 2..36 returns one error word straight away. Text
// longer than 64 characters is cut and flagged on its last word.
module integer_to_text_formatter_top (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [63:0] in_value,
  input  wire logic [5:0]  in_radix,
  input  wire logic [6:0]  in_field_width,
  input  wire logic [6:0]  in_min_digits,
  input  wire logic [6:0]  in_format_flags,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [7:0]       out_text_char,
  output logic             out_last_char,
  output logic             out_bad_radix,
  output logic             out_truncated
);

  // Control registers
  itf_pkg::itf_state_t state_r, state_nxt;
  logic [6:0]  run_r, run_nxt;
  logic [5:0]  bit_r, bit_nxt;
  logic        qnz_r, qnz_nxt;
  logic [6:0]  dcnt_r, dcnt_nxt;
  logic [6:0]  ocnt_r, ocnt_nxt;
  logic        out_valid_r, out_valid_nxt;

  // Data registers
  logic [63:0] work_r, work_nxt;
  logic [5:0]  rem_r, rem_nxt;
  logic [5:0]  radix_r, radix_nxt;
  logic [6:0]  width_r, width_nxt;
  logic [6:0]  mind_r, mind_nxt;
  logic        zpad_r, zpad_nxt;
  logic        left_r, left_nxt;
  logic        upper_r, upper_nxt;
  logic        sign_r, sign_nxt;
  logic [7:0]  sign_char_r, sign_char_nxt;
  logic [1:0]  pre_len_r, pre_len_nxt;
  logic [6:0]  rest_r, rest_nxt;
  logic [6:0]  pz_r, pz_nxt;
  logic [6:0]  limit_r, limit_nxt;
  logic        cut_r, cut_nxt;
  logic [itf_pkg::DIGIT_AW-1:0] rd_idx_r, rd_idx_nxt;
  logic [7:0]  out_char_r, out_char_nxt;
  logic        out_last_r, out_last_nxt;
  logic        out_bad_r, out_bad_nxt;
  logic        out_trunc_r, out_trunc_nxt;

  // Digit store
  logic [5:0]  digit_mem [itf_pkg::DIGIT_DEPTH];
  logic [5:0]  rd_data_r;
  logic        wr_en;
  logic [itf_pkg::DIGIT_AW-1:0] wr_addr;
  logic [5:0]  wr_data;

  // Combinational helpers
  logic        in_fire;
  logic        slot_free;
  logic [63:0] mag;
  logic        neg;
  logic [6:0]  shifted;
  logic        ge;
  logic [6:0]  diff;
  logic [5:0]  rem_new;
  logic [6:0]  prec;
  logic [7:0]  body;
  logic        wide;
  logic [7:0]  total;
  logic        emit;
  logic [7:0]  emit_char;
  logic        emit_last;

  assign in_ready      = (state_r == itf_pkg::ST_IDLE);
  assign in_fire       = in_valid && in_ready;
  assign slot_free     = !out_valid_r || out_ready;
  assign out_valid     = out_valid_r;
  assign out_text_char = out_char_r;
  assign out_last_char = out_last_r;
  assign out_bad_radix = out_bad_r;
  assign out_truncated = out_trunc_r;

  // Magnitude of the incoming value
  assign neg = in_format_flags[itf_pkg::FL_SIGNED] && in_value[63];
  assign mag = neg ? (~in_value + 64'd1) : in_value;

  // One restoring divide step
  assign shifted = {rem_r, work_r[63]};
  assign ge      = shifted >= {1'b0, radix_r};
  assign diff    = shifted - {1'b0, radix_r};
  assign rem_new = ge ? diff[5:0] : shifted[5:0];

  // Layout sums for the setup cycle
  assign prec  = (mind_r > dcnt_r) ? mind_r : dcnt_r;
  assign body  = {1'b0, prec} + {7'd0, sign_r} + {6'd0, pre_len_r};
  assign wide  = {1'b0, width_r} > body;
  assign total = wide ? {1'b0, width_r} : body;

  // Last word of the text
  assign emit_last = ((ocnt_r + 7'd1) == limit_r);

  // Next state and outputs
  always_comb begin
    state_nxt     = state_r;
    run_nxt       = run_r;
    bit_nxt       = bit_r;
    qnz_nxt       = qnz_r;
    dcnt_nxt      = dcnt_r;
    ocnt_nxt      = ocnt_r;
    work_nxt      = work_r;
    rem_nxt       = rem_r;
    radix_nxt     = radix_r;
    width_nxt     = width_r;
    mind_nxt      = mind_r;
    zpad_nxt      = zpad_r;
    left_nxt      = left_r;
    upper_nxt     = upper_r;
    sign_nxt      = sign_r;
    sign_char_nxt = sign_char_r;
    pre_len_nxt   = pre_len_r;
    rest_nxt      = rest_r;
    pz_nxt        = pz_r;
    limit_nxt     = limit_r;
    cut_nxt       = cut_r;
    rd_idx_nxt    = rd_idx_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_char_nxt  = out_char_r;
    out_last_nxt  = out_last_r;
    out_bad_nxt   = out_bad_r;
    out_trunc_nxt = out_trunc_r;
    wr_en         = 1'b0;
    wr_addr       = dcnt_r[itf_pkg::DIGIT_AW-1:0];
    wr_data       = rem_new;
    emit          = 1'b0;
    emit_char     = itf_pkg::CH_SPACE;

    unique case (state_r)
      itf_pkg::ST_IDLE: begin
        if (in_fire) begin
          if (in_radix < itf_pkg::RADIX_MIN || in_radix > itf_pkg::RADIX_MAX) begin
            state_nxt = itf_pkg::ST_ERR;
          end else begin
            state_nxt = itf_pkg::ST_DIV;
            work_nxt  = mag;
            rem_nxt   = 6'd0;
            bit_nxt   = 6'd0;
            qnz_nxt   = 1'b0;
            dcnt_nxt  = 7'd0;
            radix_nxt = in_radix;
            width_nxt = in_field_width;
            mind_nxt  = in_min_digits;
            left_nxt  = in_format_flags[itf_pkg::FL_LEFT];
            zpad_nxt  = in_format_flags[itf_pkg::FL_ZEROPAD]
                        && !in_format_flags[itf_pkg::FL_LEFT];
            upper_nxt = in_format_flags[itf_pkg::FL_UPPER];
            // Pick the sign character
            sign_nxt      = 1'b0;
            sign_char_nxt = itf_pkg::CH_SPACE;
            if (in_format_flags[itf_pkg::FL_SIGNED]) begin
              if (in_value[63]) begin
                sign_nxt      = 1'b1;
                sign_char_nxt = itf_pkg::CH_MINUS;
              end else if (in_format_flags[itf_pkg::FL_PLUS]) begin
                sign_nxt      = 1'b1;
                sign_char_nxt = itf_pkg::CH_PLUS;
              end else if (in_format_flags[itf_pkg::FL_SPACE]) begin
                sign_nxt      = 1'b1;
                sign_char_nxt = itf_pkg::CH_SPACE;
              end
            end
            // Prefix length
            pre_len_nxt = 2'd0;
            if (in_format_flags[itf_pkg::FL_PREFIX]) begin
              if (in_radix == itf_pkg::RADIX_HEX) begin
                pre_len_nxt = 2'd2;
              end else if (in_radix == itf_pkg::RADIX_OCT) begin
                pre_len_nxt = 2'd1;
              end
            end
          end
        end
      end

      // Retire one quotient bit per cycle; store the remainder after the last bit
      itf_pkg::ST_DIV: begin
        work_nxt = {work_r[62:0], ge};
        rem_nxt  = rem_new;
        qnz_nxt  = qnz_r | ge;
        bit_nxt  = bit_r + 6'd1;
        if (bit_r == 6'h3f) begin
          if (dcnt_r < 7'(itf_pkg::DIGIT_DEPTH)) begin
            wr_en    = 1'b1;
            dcnt_nxt = dcnt_r + 7'd1;
          end
          rem_nxt = 6'd0;
          qnz_nxt = 1'b0;
          if (!(qnz_r | ge)) begin
            state_nxt = itf_pkg::ST_SETUP;
          end
        end
      end

      // Work out the padding runs and the text length
      itf_pkg::ST_SETUP: begin
        rest_nxt   = wide ? (width_r - body[6:0]) : 7'd0;
        cut_nxt    = total > itf_pkg::MAX_CHARS;
        limit_nxt  = (total > itf_pkg::MAX_CHARS) ? itf_pkg::MAX_CHARS[6:0] : total[6:0];
        pz_nxt     = prec - dcnt_r;
        rd_idx_nxt = itf_pkg::DIGIT_AW'(dcnt_r - 7'd1);
        ocnt_nxt   = 7'd0;
        run_nxt    = (!zpad_r && !left_r) ? (wide ? (width_r - body[6:0]) : 7'd0) : 7'd0;
        state_nxt  = itf_pkg::ST_LSP;
      end

      itf_pkg::ST_LSP: begin
        emit_char = itf_pkg::CH_SPACE;
        if (run_r == 7'd0) begin
          state_nxt = itf_pkg::ST_SIGN;
          run_nxt   = {6'd0, sign_r};
        end else begin
          emit = slot_free;
        end
      end

      itf_pkg::ST_SIGN: begin
        emit_char = sign_char_r;
        if (run_r == 7'd0) begin
          state_nxt = itf_pkg::ST_PRE0;
          run_nxt   = {6'd0, (pre_len_r != 2'd0)};
        end else begin
          emit = slot_free;
        end
      end

      itf_pkg::ST_PRE0: begin
        emit_char = itf_pkg::CH_ZERO;
        if (run_r == 7'd0) begin
          state_nxt = itf_pkg::ST_PREX;
          run_nxt   = {6'd0, (pre_len_r == 2'd2)};
        end else begin
          emit = slot_free;
        end
      end

      itf_pkg::ST_PREX: begin
        emit_char = upper_r ? itf_pkg::CH_UX : itf_pkg::CH_LX;
        if (run_r == 7'd0) begin
          state_nxt = itf_pkg::ST_ZPAD;
          run_nxt   = zpad_r ? rest_r : 7'd0;
        end else begin
          emit = slot_free;
        end
      end

      itf_pkg::ST_ZPAD: begin
        emit_char = itf_pkg::CH_ZERO;
        if (run_r == 7'd0) begin
          state_nxt = itf_pkg::ST_PZERO;
          run_nxt   = pz_r;
        end else begin
          emit = slot_free;
        end
      end

      itf_pkg::ST_PZERO: begin
        emit_char = itf_pkg::CH_ZERO;
        if (run_r == 7'd0) begin
          state_nxt = itf_pkg::ST_DFETCH;
          run_nxt   = dcnt_r;
        end else begin
          emit = slot_free;
        end
      end

      // Let the registered digit store read settle before the digit goes out
      itf_pkg::ST_DFETCH: begin
        if (run_r == 7'd0) begin
          state_nxt = itf_pkg::ST_TSP;
          run_nxt   = left_r ? rest_r : 7'd0;
        end else begin
          state_nxt = itf_pkg::ST_DEMIT;
        end
      end

      itf_pkg::ST_DEMIT: begin
        emit_char = itf_pkg::digit_char(rd_data_r, upper_r);
        emit      = slot_free;
        if (slot_free) begin
          rd_idx_nxt = rd_idx_r - itf_pkg::DIGIT_AW'(1);
          state_nxt  = itf_pkg::ST_DFETCH;
        end
      end

      itf_pkg::ST_TSP: begin
        emit_char = itf_pkg::CH_SPACE;
        if (run_r == 7'd0) begin
          state_nxt = itf_pkg::ST_IDLE;
        end else begin
          emit = slot_free;
        end
      end

      // Single error word, no text
      itf_pkg::ST_ERR: begin
        if (slot_free) begin
          out_valid_nxt = 1'b1;
          out_char_nxt  = itf_pkg::CH_NUL;
          out_last_nxt  = 1'b1;
          out_bad_nxt   = 1'b1;
          out_trunc_nxt = 1'b0;
          state_nxt     = itf_pkg::ST_IDLE;
        end
      end

      default: begin
        state_nxt = itf_pkg::ST_IDLE;
      end
    endcase

    // Load one character into the output register
    if (emit) begin
      out_valid_nxt = 1'b1;
      out_char_nxt  = emit_char;
      out_last_nxt  = emit_last;
      out_bad_nxt   = 1'b0;
      out_trunc_nxt = emit_last && cut_r;
      run_nxt       = run_r - 7'd1;
      ocnt_nxt      = ocnt_r + 7'd1;
      if (emit_last) begin
        state_nxt = itf_pkg::ST_IDLE;
      end
    end
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= itf_pkg::ST_IDLE;
      run_r       <= 7'd0;
      bit_r       <= 6'd0;
      qnz_r       <= 1'b0;
      dcnt_r      <= 7'd0;
      ocnt_r      <= 7'd0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      run_r       <= run_nxt;
      bit_r       <= bit_nxt;
      qnz_r       <= qnz_nxt;
      dcnt_r      <= dcnt_nxt;
      ocnt_r      <= ocnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload and working values
  always_ff @(posedge clk) begin
    work_r      <= work_nxt;
    rem_r       <= rem_nxt;
    radix_r     <= radix_nxt;
    width_r     <= width_nxt;
    mind_r      <= mind_nxt;
    zpad_r      <= zpad_nxt;
    left_r      <= left_nxt;
    upper_r     <= upper_nxt;
    sign_r      <= sign_nxt;
    sign_char_r <= sign_char_nxt;
    pre_len_r   <= pre_len_nxt;
    rest_r      <= rest_nxt;
    pz_r        <= pz_nxt;
    limit_r     <= limit_nxt;
    cut_r       <= cut_nxt;
    rd_idx_r    <= rd_idx_nxt;
    out_char_r  <= out_char_nxt;
    out_last_r  <= out_last_nxt;
    out_bad_r   <= out_bad_nxt;
    out_trunc_r <= out_trunc_nxt;
  end

  // Digit store: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      digit_mem[wr_addr] <= wr_data;
    end
    rd_data_r <= digit_mem[rd_idx_r];
  end

endmodule
`default_nettype wire

>>> tb/tb_integer_to_text_formatter_top.sv
// Self-checking testbench for the integer-to-text formatter: predicted text versus emitted words.
`timescale 1ns / 1ps

module tb_integer_to_text_formatter_top;

  localparam int          HOLD_CYCLES = 300;
  localparam int          TAIL_CYCLES = 40;
  localparam longint     LIMIT_NS    = 40_000_000;

  // Format flag masks
  localparam logic [6:0] F_ZPAD   = 7'd1 << itf_pkg::FL_ZEROPAD;
  localparam logic [6:0] F_SIGNED = 7'd1 << itf_pkg::FL_SIGNED;
  localparam logic [6:0] F_PLUS   = 7'd1 << itf_pkg::FL_PLUS;
  localparam logic [6:0] F_SPACE  = 7'd1 << itf_pkg::FL_SPACE;
  localparam logic [6:0] F_LEFT   = 7'd1 << itf_pkg::FL_LEFT;
  localparam logic [6:0] F_PREFIX = 7'd1 << itf_pkg::FL_PREFIX;
  localparam logic [6:0] F_UPPER  = 7'd1 << itf_pkg::FL_UPPER;
  localparam logic [6:0] F_NONE   = 7'd0;

  localparam logic [63:0] ALL_ONES = 64'hffff_ffff_ffff_ffff;
  localparam logic [63:0] MOST_NEG = 64'h8000_0000_0000_0000;
  localparam logic [63:0] MOST_POS = 64'h7fff_ffff_ffff_ffff;

  typedef struct packed {
    logic [7:0] text_char;
    logic       last_char;
    logic       bad_radix;
    logic       truncated;
  } text_word_t;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  logic [63:0] in_value;
  logic [5:0]  in_radix;
  logic [6:0]  in_field_width;
  logic [6:0]  in_min_digits;
  logic [6:0]  in_format_flags;
  logic        out_valid;
  logic        out_ready;
  logic [7:0]  out_text_char;
  logic        out_last_char;
  logic        out_bad_radix;
  logic        out_truncated;

  text_word_t pending_text_q[$];
  int         mismatch_count = 0;
  int         hold_requests  = 0;
  logic       rx_quiet       = 1'b0;
  bit         tx_quiet       = 1'b0;

  integer_to_text_formatter_top dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_value        (in_value),
    .in_radix        (in_radix),
    .in_field_width  (in_field_width),
    .in_min_digits   (in_min_digits),
    .in_format_flags (in_format_flags),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_text_char   (out_text_char),
    .out_last_char   (out_last_char),
    .out_bad_radix   (out_bad_radix),
    .out_truncated   (out_truncated)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Build the printf-style text for one value and queue its words
  function automatic void predict_text(input logic [63:0] value, input logic [5:0] radix,
                                       input logic [6:0] fw, input logic [6:0] md,
                                       input logic [6:0] flags);
    text_word_t  w;
    logic [7:0]  text_q[$];
    logic [5:0]  digit_q[$];
    logic [63:0] mag;
    logic [63:0] base;
    logic [7:0]  sign_ch;
    logic [7:0]  ch;
    logic        zpad;
    int          sign_len, pre_len, prec, pad, n_out, k;
    if (radix < itf_pkg::RADIX_MIN || radix > itf_pkg::RADIX_MAX) begin
      w.text_char = itf_pkg::CH_NUL;
      w.last_char = 1'b1;
      w.bad_radix = 1'b1;
      w.truncated = 1'b0;
      pending_text_q.push_back(w);
      return;
    end
    // left justification overrides zero padding
    zpad = flags[itf_pkg::FL_ZEROPAD] && !flags[itf_pkg::FL_LEFT];
    mag = value;
    base = {58'd0, radix};
    sign_ch = itf_pkg::CH_NUL;
    sign_len = 0;
    if (flags[itf_pkg::FL_SIGNED]) begin
      if (mag[63]) begin
        sign_ch = itf_pkg::CH_MINUS;
        mag = ~mag + 64'd1;
      end else if (flags[itf_pkg::FL_PLUS]) begin
        sign_ch = itf_pkg::CH_PLUS;
      end else if (flags[itf_pkg::FL_SPACE]) begin
        sign_ch = itf_pkg::CH_SPACE;
      end
    end
    if (sign_ch != itf_pkg::CH_NUL) sign_len = 1;
    pre_len = 0;
    if (flags[itf_pkg::FL_PREFIX]) begin
      if (radix == itf_pkg::RADIX_HEX) pre_len = 2;
      else if (radix == itf_pkg::RADIX_OCT) pre_len = 1;
    end
    // split into digits, least significant first; drop any beyond the store depth
    do begin
      if (digit_q.size() < itf_pkg::DIGIT_DEPTH) digit_q.push_back(6'(mag % base));
      mag = mag / base;
    end while (mag != 64'd0);
    prec = (int'(md) > digit_q.size()) ? int'(md) : digit_q.size();
    pad = int'(fw) - sign_len - pre_len - prec;
    if (pad < 0) pad = 0;
    if (!zpad && !flags[itf_pkg::FL_LEFT]) repeat (pad) text_q.push_back(itf_pkg::CH_SPACE);
    if (sign_len != 0) text_q.push_back(sign_ch);
    if (pre_len >= 1) text_q.push_back(itf_pkg::CH_ZERO);
    if (pre_len == 2) text_q.push_back(flags[itf_pkg::FL_UPPER] ? itf_pkg::CH_UX : itf_pkg::CH_LX);
    if (zpad) repeat (pad) text_q.push_back(itf_pkg::CH_ZERO);
    repeat (prec - digit_q.size()) text_q.push_back(itf_pkg::CH_ZERO);
    for (k = digit_q.size() - 1; k >= 0; k--) begin
      if (digit_q[k] < 6'd10) ch = itf_pkg::CH_ZERO + {2'b00, digit_q[k]};
      else ch = (flags[itf_pkg::FL_UPPER] ? itf_pkg::CH_UA : itf_pkg::CH_LA)
                + {2'b00, digit_q[k]} - 8'd10;
      text_q.push_back(ch);
    end
    if (flags[itf_pkg::FL_LEFT]) repeat (pad) text_q.push_back(itf_pkg::CH_SPACE);
    // cut at the character limit and flag the cut on the final word
    n_out = (text_q.size() > int'(itf_pkg::MAX_CHARS)) ? int'(itf_pkg::MAX_CHARS)
                                                       : text_q.size();
    for (k = 0; k < n_out; k++) begin
      w.text_char = text_q[k];
      w.last_char = (k == n_out - 1);
      w.bad_radix = 1'b0;
      w.truncated = (k == n_out - 1) && (text_q.size() > n_out);
      pending_text_q.push_back(w);
    end
  endfunction

  // Offer one value and hold it until the block takes it
  task automatic offer_value(input logic [63:0] v, input logic [5:0] r, input logic [6:0] fw,
                             input logic [6:0] md, input logic [6:0] fl);
    if (!tx_quiet && $urandom_range(99) < 9) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(4, 1)) @(posedge clk);
    end
    predict_text(v, r, fw, md, fl);
    in_value        <= v;
    in_radix        <= r;
    in_field_width  <= fw;
    in_min_digits   <= md;
    in_format_flags <= fl;
    in_valid        <= 1'b1;
    do @(posedge clk); while (!in_ready);
  endtask

  // Stop offering and wait until every predicted word has come back
  task automatic wait_for_text_drain();
    in_valid <= 1'b0;
    while (pending_text_q.size() != 0) @(posedge clk);
  endtask

  // Draw one random request, biased towards short values and valid radices
  task automatic draw_request(output logic [63:0] v, output logic [5:0] r,
                              output logic [6:0] fw, output logic [6:0] md,
                              output logic [6:0] fl);
    int pick;
    int nbits;
    fl = 7'($urandom_range(127));
    pick = $urandom_range(99);
    if (pick < 12) r = 6'($urandom_range(63));
    else if (pick < 27) r = itf_pkg::RADIX_HEX;
    else if (pick < 42) r = 6'd10;
    else if (pick < 50) r = itf_pkg::RADIX_OCT;
    else r = 6'($urandom_range(36, 2));
    pick = $urandom_range(99);
    nbits = (pick < 70) ? $urandom_range(24, 1) : $urandom_range(64, 1);
    v = {$urandom, $urandom};
    v = v >> (64 - nbits);
    pick = $urandom_range(99);
    if (fl[itf_pkg::FL_SIGNED] && pick < 35) v = ~v + 64'd1;
    else if (pick > 96) v = (pick == 99) ? ALL_ONES : (pick == 98) ? MOST_NEG : 64'd0;
    pick = $urandom_range(99);
    fw = (pick < 55) ? 7'($urandom_range(16)) :
         (pick < 85) ? 7'($urandom_range(70)) : 7'($urandom_range(127));
    pick = $urandom_range(99);
    md = (pick < 50) ? 7'd0 : (pick < 85) ? 7'($urandom_range(24)) : 7'($urandom_range(127));
  endtask

  // Layout, sign, prefix and case handling at the edges of the value range
  task automatic test_directed_formats();
    offer_value(64'd0, 6'd10, 7'd0, 7'd0, F_NONE);
    offer_value(64'd0, itf_pkg::RADIX_HEX, 7'd0, 7'd0, F_PREFIX);
    offer_value(64'd0, itf_pkg::RADIX_OCT, 7'd5, 7'd0, F_PREFIX | F_ZPAD);
    offer_value(ALL_ONES, itf_pkg::RADIX_MIN, 7'd0, 7'd0, F_NONE);
    offer_value(ALL_ONES, 6'd10, 7'd0, 7'd0, F_SIGNED);
    offer_value(MOST_NEG, 6'd10, 7'd0, 7'd0, F_SIGNED);
    offer_value(MOST_POS, itf_pkg::RADIX_MAX, 7'd0, 7'd0, F_UPPER | F_SIGNED | F_PLUS);
    offer_value(64'd255, itf_pkg::RADIX_HEX, 7'd0, 7'd0, F_PREFIX | F_UPPER);
    offer_value(64'd255, itf_pkg::RADIX_HEX, 7'd10, 7'd0, F_PREFIX | F_ZPAD);
    offer_value(64'd42, 6'd10, 7'd8, 7'd0, F_SIGNED | F_PLUS | F_LEFT);
    offer_value(64'd42, 6'd10, 7'd6, 7'd0, F_SIGNED | F_SPACE);
    offer_value(64'd42, 6'd10, 7'd0, 7'd0, F_PLUS | F_SPACE);
    offer_value(64'd42, 6'd10, 7'd4, 7'd0, F_PREFIX);
    offer_value(-64'sd5, 6'd10, 7'd6, 7'd0, F_SIGNED | F_ZPAD | F_LEFT);
    offer_value(64'd7, 6'd10, 7'd10, 7'd5, F_NONE);
    offer_value(ALL_ONES, itf_pkg::RADIX_HEX, 7'd20, 7'd18, 7'h7f);
    offer_value(ALL_ONES, itf_pkg::RADIX_MAX, 7'd0, 7'd0, F_NONE);
    wait_for_text_drain();
  endtask

  // Radices outside the valid range give a single error word
  task automatic test_bad_radix();
    offer_value(64'd123, 6'd0, 7'd10, 7'd3, F_SIGNED);
    offer_value(ALL_ONES, 6'd1, 7'd127, 7'd127, 7'h7f);
    offer_value(64'd0, 6'd37, 7'd0, 7'd0, F_PREFIX);
    offer_value(MOST_NEG, 6'd63, 7'd64, 7'd64, F_LEFT);
    wait_for_text_drain();
  endtask

  // Text at and beyond the character limit
  task automatic test_truncation();
    offer_value(64'd1, 6'd10, 7'd127, 7'd0, F_NONE);
    offer_value(64'd1, 6'd10, 7'd0, 7'd127, F_NONE);
    offer_value(64'd12345, 6'd10, 7'd64, 7'd0, F_NONE);
    offer_value(64'd12345, 6'd10, 7'd65, 7'd0, F_LEFT);
    offer_value(MOST_NEG, itf_pkg::RADIX_MIN, 7'd0, 7'd0, F_SIGNED);
    wait_for_text_drain();
  endtask

  // Hold off the output for a long stretch while values keep coming
  task automatic test_backpressure();
    logic [6:0] fw;
    tx_quiet = 1'b1;
    hold_requests <= hold_requests + 1;
    repeat (6) begin
      fw = 7'($urandom_range(20));
      offer_value(64'($urandom_range(65535)), itf_pkg::RADIX_HEX, fw, 7'd0,
                  7'($urandom_range(127)));
    end
    tx_quiet = 1'b0;
    wait_for_text_drain();
  endtask

  // Pause the input until the block has emptied, then carry on
  task automatic test_drain_pause();
    logic [63:0] v;
    logic [5:0]  r;
    logic [6:0]  fw, md, fl;
    repeat (4) begin
      draw_request(v, r, fw, md, fl);
      offer_value(v, r, fw, md, fl);
    end
    wait_for_text_drain();
    repeat (4) begin
      draw_request(v, r, fw, md, fl);
      offer_value(v, r, fw, md, fl);
    end
    wait_for_text_drain();
  endtask

  // Random requests, optionally with no idling on either side
  task automatic test_random_values(input int count, input bit quiet);
    logic [63:0] v;
    logic [5:0]  r;
    logic [6:0]  fw, md, fl;
    tx_quiet = quiet;
    rx_quiet <= quiet;
    repeat (count) begin
      draw_request(v, r, fw, md, fl);
      offer_value(v, r, fw, md, fl);
    end
    wait_for_text_drain();
    tx_quiet = 1'b0;
    rx_quiet <= 1'b0;
  endtask

  // Receiver: random stalls, quiet stretches and a requested long hold-off
  initial begin
    int served_holds;
    served_holds = 0;
    out_ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_requests != served_holds) begin
        served_holds++;
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else if (rx_quiet) begin
        out_ready <= 1'b1;
      end else begin
        out_ready <= ($urandom_range(99) >= 9);
      end
    end
  end

  // Compare each accepted word with the oldest prediction
  always @(posedge clk) begin
    text_word_t got;
    text_word_t want;
    if (rst_n && out_valid && out_ready) begin
      got = {out_text_char, out_last_char, out_bad_radix, out_truncated};
      if (pending_text_q.size() == 0) begin
        mismatch_count++;
        $display("%0t: unexpected word exp none, got char=%02h last=%b bad=%b cut=%b",
                 $time, got.text_char, got.last_char, got.bad_radix, got.truncated);
      end else begin
        want = pending_text_q.pop_front();
        if (got !== want) begin
          mismatch_count++;
          $display("%0t: word mismatch exp char=%02h last=%b bad=%b cut=%b,",
                   $time, want.text_char, want.last_char, want.bad_radix, want.truncated);
          $display("%0t:   got char=%02h last=%b bad=%b cut=%b",
                   $time, got.text_char, got.last_char, got.bad_radix, got.truncated);
        end
      end
    end
  end

  // Overall time limit
  initial begin
    #(LIMIT_NS);
    $display("TEST FAILED");
    $finish;
  end

  initial begin
    rst_n           <= 1'b0;
    in_valid        <= 1'b0;
    in_value        <= 64'd0;
    in_radix        <= 6'd0;
    in_field_width  <= 7'd0;
    in_min_digits   <= 7'd0;
    in_format_flags <= 7'd0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    test_directed_formats();
    test_bad_radix();
    test_truncation();
    test_random_values(70, 1'b1);
    test_backpressure();
    test_random_values(220, 1'b0);
    test_drain_pause();
    // let any stray words show up before the verdict
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && pending_text_q.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
